@@ src/bpu_pkg.sv @@
// ----------------------------------------------------------------------------
// bpu_pkg
// Types and constants for the bitmap pixel unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package bpu_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int WIDTH_W     = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KIND  = 2'd2;

    typedef enum logic [2:0] {
        DEPTH_1    = 3'd0,
        DEPTH_2    = 3'd1,
        DEPTH_4    = 3'd2,
        DEPTH_8    = 3'd3,
        DEPTH_16   = 3'd4,
        DEPTH_24   = 3'd5,
        DEPTH_32   = 3'd6,
        DEPTH_NONE = 3'd7
    } depth_t;

    typedef enum logic [1:0] {
        KIND_COLOR = 2'd0,
        KIND_601   = 2'd1,
        KIND_709   = 2'd2
    } kind_t;

    localparam logic [15:0] Q601_R = 16'd19595;
    localparam logic [15:0] Q601_G = 16'd38470;
    localparam logic [15:0] Q601_B = 16'd7471;
    localparam logic [15:0] Q709_R = 16'd13933;
    localparam logic [15:0] Q709_G = 16'd46871;
    localparam logic [15:0] Q709_B = 16'd4732;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

endpackage

`default_nettype wire

@@ src/bpu_ram.sv @@
// ----------------------------------------------------------------------------
// bpu_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/bitmap_pixel_unpacker_top.sv @@
// ----------------------------------------------------------------------------
// bitmap_pixel_unpacker_top
// Unpacks 32-bit bitmap row words into pixels, with palette lookup and luma.
// ----------------------------------------------------------------------------
// Each row word yields one pixel per cycle on the output while the output is
// not stalled: 32/bpp pixels for the palette depths, 2 at 16 bits, 1 or 2 at
// 24 bits and 1 at 32 bits, and fewer when the row ends inside the word. The
// single unpacking stage issues one palette read per cycle while not stalled;
// the next word is taken in the cycle its predecessor's last pixel is issued,
// so words can follow back to back. A palette load is held off while a word
// is being unpacked, until the cycle in which its last pixel is issued. Each
// issued pixel passes through the palette read, product and output registers
// before it reaches the output. A stalled output holds every stage.
`default_nettype none

module bitmap_pixel_unpacker_top #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int MAX_ROW_PIXELS  = 4096
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [bpu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bpu_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [39:0]                     s_tdata,  // data_word, entry_number
    input  wire logic                            s_tuser,  // mode
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [39:0]                          m_tdata,  // red, green, blue, alpha, luma
    output logic                                 m_tuser,  // row_end
    output logic                                 m_tlast   // last
);

    import bpu_pkg::*;

    localparam int AW    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int POS_W = $clog2(MAX_ROW_PIXELS + 1);
    localparam int CMP_W = (POS_W > WIDTH_W) ? POS_W : WIDTH_W;

    // Configuration
    depth_t               depth_reg;
    logic [WIDTH_W-1:0]   width_reg;
    kind_t                kind_reg;
    logic [POS_W-1:0]     limit;
    logic [CMP_W-1:0]     width_ext;
    logic                 restart;

    // Unpacking stage
    logic                 a_busy_reg, a_busy_next;
    logic [47:0]          a_sh_reg, a_sh_next;
    logic [5:0]           a_left_reg, a_left_next;
    logic [1:0]           a_cc_after_reg, a_cc_after_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [15:0]          carry_reg, carry_next;
    logic [1:0]           cc_reg, cc_next;

    logic [POS_W:0]       pos_inc;
    logic                 a_end;
    logic                 a_last;
    logic                 a_pal;
    logic [7:0]           a_idx;
    pix_t                 a_pix;
    logic [47:0]          a_sh_step;

    logic                 adv;
    logic                 s_acc;
    logic                 load_a;
    logic                 pal_we;
    logic [31:0]          in_word;
    logic [7:0]           in_entry;
    logic [31:0]          in_be;

    // Palette read stage
    logic                 b_v_reg;
    logic                 b_pal_reg;
    logic                 b_zero_reg;
    pix_t                 b_pix_reg;
    logic                 b_row_end_reg;
    logic                 b_last_reg;
    logic [31:0]          pal_rdata;
    pix_t                 b_pix;

    // Product stage
    logic                 c_v_reg;
    pix_t                 c_pix_reg;
    logic [23:0]          c_pr_reg, c_pg_reg, c_pb_reg;
    logic                 c_row_end_reg;
    logic                 c_last_reg;
    logic [15:0]          coef_r, coef_g, coef_b;

    // Output stage
    logic                 d_v_reg;
    pix_t                 d_pix_reg;
    logic [7:0]           d_luma_reg;
    logic                 d_row_end_reg;
    logic                 d_last_reg;
    logic [24:0]          luma_sum;

    assign in_word  = s_tdata[31:0];
    assign in_entry = s_tdata[39:32];
    assign in_be    = {in_word[7:0], in_word[15:8], in_word[23:16], in_word[31:24]};

    assign width_ext = CMP_W'(width_reg);
    always_comb
    begin
        if (width_reg == '0)
        begin
            limit = POS_W'(1);
        end
        else if (width_ext > CMP_W'(MAX_ROW_PIXELS))
        begin
            limit = POS_W'(MAX_ROW_PIXELS);
        end
        else
        begin
            limit = POS_W'(width_ext);
        end
    end

    assign restart = cfg_we && ((cfg_index == REG_DEPTH) || (cfg_index == REG_WIDTH));

    assign adv    = !d_v_reg || m_tready;
    assign pos_inc = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign a_end  = pos_inc >= {1'b0, limit};
    assign a_last = (a_left_reg == 6'd1) || a_end;

    assign s_tready = !a_busy_reg || (adv && a_last);
    assign s_acc    = s_tvalid && s_tready;
    assign load_a   = s_acc && s_tuser && (depth_reg != DEPTH_NONE);
    assign pal_we   = s_acc && !s_tuser && (9'(in_entry) < 9'(PALETTE_ENTRIES));

    // Current pixel of the held word
    always_comb
    begin
        a_pal     = 1'b0;
        a_idx     = 8'd0;
        a_pix     = '0;
        a_sh_step = a_sh_reg;
        case (depth_reg)
            DEPTH_1:
            begin
                a_pal     = 1'b1;
                a_idx     = {7'd0, a_sh_reg[31]};
                a_sh_step = {16'd0, a_sh_reg[30:0], 1'b0};
            end
            DEPTH_2:
            begin
                a_pal     = 1'b1;
                a_idx     = {6'd0, a_sh_reg[31:30]};
                a_sh_step = {16'd0, a_sh_reg[29:0], 2'd0};
            end
            DEPTH_4:
            begin
                a_pal     = 1'b1;
                a_idx     = {4'd0, a_sh_reg[31:28]};
                a_sh_step = {16'd0, a_sh_reg[27:0], 4'd0};
            end
            DEPTH_8:
            begin
                a_pal     = 1'b1;
                a_idx     = a_sh_reg[31:24];
                a_sh_step = {16'd0, a_sh_reg[23:0], 8'd0};
            end
            DEPTH_16:
            begin
                a_pix.red   = {4'd0, a_sh_reg[11:8]};
                a_pix.green = {4'd0, a_sh_reg[7:4]};
                a_pix.blue  = {4'd0, a_sh_reg[3:0]};
                a_pix.alpha = {4'd0, a_sh_reg[15:12]};
                a_sh_step   = {16'd0, a_sh_reg[47:16]};
            end
            DEPTH_24:
            begin
                a_pix.red   = a_sh_reg[23:16];
                a_pix.green = a_sh_reg[15:8];
                a_pix.blue  = a_sh_reg[7:0];
                a_sh_step   = {24'd0, a_sh_reg[47:24]};
            end
            DEPTH_32:
            begin
                a_pix.red   = a_sh_reg[23:16];
                a_pix.green = a_sh_reg[15:8];
                a_pix.blue  = a_sh_reg[7:0];
                a_pix.alpha = a_sh_reg[31:24];
            end
            default:
            begin
                a_pal = 1'b0;
            end
        endcase
    end

    // Unpacking stage next state
    always_comb
    begin
        a_busy_next     = a_busy_reg;
        a_sh_next       = a_sh_reg;
        a_left_next     = a_left_reg;
        a_cc_after_next = a_cc_after_reg;
        pos_next        = pos_reg;
        carry_next      = carry_reg;
        cc_next         = cc_reg;

        if (a_busy_reg && adv)
        begin
            a_sh_next   = a_sh_step;
            a_left_next = a_left_reg - 6'd1;
            pos_next    = a_end ? '0 : pos_inc[POS_W-1:0];
            if (a_last)
            begin
                a_busy_next = 1'b0;
                if (depth_reg == DEPTH_24)
                begin
                    carry_next = a_end ? 16'd0 : a_sh_step[15:0];
                    cc_next    = a_end ? 2'd0 : a_cc_after_reg;
                end
            end
        end

        if (load_a)
        begin
            a_busy_next = 1'b1;
            a_sh_next   = {16'd0, in_word};
            case (depth_reg)
                DEPTH_1:
                begin
                    a_sh_next   = {16'd0, in_be};
                    a_left_next = 6'd32;
                end
                DEPTH_2:
                begin
                    a_sh_next   = {16'd0, in_be};
                    a_left_next = 6'd16;
                end
                DEPTH_4:
                begin
                    a_sh_next   = {16'd0, in_be};
                    a_left_next = 6'd8;
                end
                DEPTH_8:
                begin
                    a_sh_next   = {16'd0, in_be};
                    a_left_next = 6'd4;
                end
                DEPTH_16:
                begin
                    a_left_next = 6'd2;
                end
                DEPTH_24:
                begin
                    case (cc_next)
                        2'd1:
                        begin
                            a_sh_next       = {8'd0, in_word, carry_next[7:0]};
                            a_left_next     = 6'd1;
                            a_cc_after_next = 2'd2;
                        end
                        2'd2:
                        begin
                            a_sh_next       = {in_word, carry_next};
                            a_left_next     = 6'd2;
                            a_cc_after_next = 2'd0;
                        end
                        default:
                        begin
                            a_left_next     = 6'd1;
                            a_cc_after_next = 2'd1;
                        end
                    endcase
                end
                default:
                begin
                    a_left_next = 6'd1;
                end
            endcase
        end

        // A new depth or width starts the row again.
        if (restart)
        begin
            pos_next   = '0;
            carry_next = '0;
            cc_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= DEPTH_8;
            width_reg  <= WIDTH_W'(1);
            kind_reg   <= KIND_COLOR;
            a_busy_reg <= 1'b0;
            pos_reg    <= '0;
            carry_reg  <= '0;
            cc_reg     <= '0;
        end
        else
        begin
            a_busy_reg <= a_busy_next;
            pos_reg    <= pos_next;
            carry_reg  <= carry_next;
            cc_reg     <= cc_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEPTH:
                    begin
                        depth_reg <= depth_t'(cfg_data[2:0]);
                    end
                    REG_WIDTH:
                    begin
                        width_reg <= cfg_data[WIDTH_W-1:0];
                    end
                    REG_KIND:
                    begin
                        kind_reg <= kind_t'(cfg_data[1:0]);
                    end
                    default:
                    begin
                        kind_reg <= kind_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_sh_reg       <= a_sh_next;
        a_left_reg     <= a_left_next;
        a_cc_after_reg <= a_cc_after_next;
    end

    bpu_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (in_entry[AW-1:0]),
        .wdata (in_word),
        .re    (adv),
        .raddr (a_idx[AW-1:0]),
        .rdata (pal_rdata)
    );

    // Valid flags of the palette read, product and output stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_v_reg <= a_busy_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
        end
    end

    always_comb
    begin
        if (!b_pal_reg)
        begin
            b_pix = b_pix_reg;
        end
        else if (b_zero_reg)
        begin
            b_pix = '0;
        end
        else
        begin
            b_pix.red   = pal_rdata[23:16];
            b_pix.green = pal_rdata[15:8];
            b_pix.blue  = pal_rdata[7:0];
            b_pix.alpha = pal_rdata[31:24];
        end
    end

    always_comb
    begin
        case (kind_reg)
            KIND_601:
            begin
                coef_r = Q601_R;
                coef_g = Q601_G;
                coef_b = Q601_B;
            end
            KIND_709:
            begin
                coef_r = Q709_R;
                coef_g = Q709_G;
                coef_b = Q709_B;
            end
            default:
            begin
                coef_r = 16'd0;
                coef_g = 16'd0;
                coef_b = 16'd0;
            end
        endcase
    end

    assign luma_sum = 25'(c_pr_reg) + 25'(c_pg_reg) + 25'(c_pb_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_pal_reg     <= a_pal;
            b_zero_reg    <= 9'(a_idx) >= 9'(PALETTE_ENTRIES);
            b_pix_reg     <= a_pix;
            b_row_end_reg <= a_end;
            b_last_reg    <= a_last;

            c_pix_reg     <= b_pix;
            c_pr_reg      <= 24'(b_pix.red) * 24'(coef_r);
            c_pg_reg      <= 24'(b_pix.green) * 24'(coef_g);
            c_pb_reg      <= 24'(b_pix.blue) * 24'(coef_b);
            c_row_end_reg <= b_row_end_reg;
            c_last_reg    <= b_last_reg;

            d_pix_reg     <= c_pix_reg;
            d_luma_reg    <= luma_sum[23:16];
            d_row_end_reg <= c_row_end_reg;
            d_last_reg    <= c_last_reg;
        end
    end

    assign m_tvalid = d_v_reg;
    assign m_tdata  = {d_luma_reg, d_pix_reg.alpha, d_pix_reg.blue, d_pix_reg.green,
                       d_pix_reg.red};
    assign m_tuser  = d_row_end_reg;
    assign m_tlast  = d_last_reg;

endmodule

`default_nettype wire
